FILE: rtl/ldl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldl_pkg: shared types and codes for the lazy deletion list table
// Item layouts, operation and status codes, and the stored entry format.
// ----------------------------------------------------------------------------
package ldl_pkg;

    localparam logic [2:0] OP_INSERT     = 3'd0;
    localparam logic [2:0] OP_DEL_NEWEST = 3'd1;
    localparam logic [2:0] OP_DEL_OLDEST = 3'd2;
    localparam logic [2:0] OP_DEL_VALUE  = 3'd3;
    localparam logic [2:0] OP_RESTORE    = 3'd4;
    localparam logic [2:0] OP_COUNT      = 3'd5;

    localparam logic [1:0] ST_NONE = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [6:0] valid_count;
    } out_item_t;

    // One table slot: valid mark and stored value
    typedef struct packed {
        logic        live;
        logic [31:0] value;
    } entry_t;

endpackage

FILE: rtl/ldl_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldl_mem: entry store
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ldl_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic            clk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  ldl_pkg::entry_t wr_data,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    output ldl_pkg::entry_t rd_data
);

    ldl_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/lazy_delete_list_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lazy_delete_list_table: ordered table of 32-bit values with lazy deletion
// Insert appends at the newest end; deletes only clear the valid mark, and
// restore sets it again. Entries live in one synchronous memory, scanned one
// slot per cycle for the delete and restore operations.
// ----------------------------------------------------------------------------
//
//  channel | ports                 | handshake
//  --------+-----------------------+--------------------------------------
//  item in | start, busy, in_item  | taken at a clock edge with start high
//          |                       | and busy low
//  result  | done, result          | done high for one cycle, no stall
//
//  Insert, count, unused codes, and delete or restore on an empty table: result
//  in the cycle after the item is taken; busy stays low, so an item may follow
//  in every cycle. Delete and restore otherwise: busy while the scan runs (one
//  memory read per slot through the single read port, plus the check of the last
//  read), and the result shows in the same cycle that busy drops.
//  Reset needs no clearing pass: the fill count keeps every scan inside
//  written slots. The receiver cannot stall, so results are never held.
// ----------------------------------------------------------------------------
module lazy_delete_list_table #(
    parameter int DEPTH = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  ldl_pkg::in_item_t   in_item,
    output logic                done,
    output ldl_pkg::out_item_t  result
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    // Control state
    logic                state_reg, state_next;
    logic [CW-1:0]       occ_reg, occ_next;
    logic [CW-1:0]       live_reg, live_next;
    logic [CW-1:0]       left_reg, left_next;
    logic                pend_reg, pend_next;
    logic                done_reg, done_next;

    // Payload state
    logic [2:0]          kind_reg, kind_next;
    logic [31:0]         key_reg, key_next;
    logic [AW-1:0]       addr_reg, addr_next;
    logic [AW-1:0]       paddr_reg, paddr_next;
    ldl_pkg::out_item_t  result_reg, result_next;

    // Memory port
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    ldl_pkg::entry_t     wr_data;
    logic                rd_en;
    ldl_pkg::entry_t     rd_data;

    // Scan qualifiers for the operation held in kind_reg
    logic                want_live;
    logic                use_key;
    logic                go_down;
    logic                hit;
    logic [CW-1:0]       occ_m1;

    ldl_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    assign busy   = (state_reg == S_SCAN);
    assign done   = done_reg;
    assign result = result_reg;

    assign want_live = (kind_reg != ldl_pkg::OP_RESTORE);
    assign use_key   = (kind_reg == ldl_pkg::OP_DEL_VALUE) ||
                       (kind_reg == ldl_pkg::OP_RESTORE);
    assign go_down   = (kind_reg != ldl_pkg::OP_DEL_OLDEST);
    assign occ_m1    = occ_reg - CW'(1);

    // A returned entry qualifies when its mark is in the wanted state and,
    // for the value operations, the stored pattern equals the key.
    assign hit = pend_reg && (rd_data.live == want_live) &&
                 (!use_key || (rd_data.value == key_reg));

    always_comb
    begin
        state_next  = state_reg;
        occ_next    = occ_reg;
        live_next   = live_reg;
        left_next   = left_reg;
        pend_next   = 1'b0;
        done_next   = 1'b0;
        kind_next   = kind_reg;
        key_next    = key_reg;
        addr_next   = addr_reg;
        paddr_next  = paddr_reg;
        result_next = result_reg;
        wr_en       = 1'b0;
        wr_addr     = occ_reg[AW-1:0];
        wr_data     = '{live: 1'b1, value: in_item.value};
        rd_en       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    kind_next = in_item.kind;
                    key_next  = in_item.value;
                    case (in_item.kind) inside
                        ldl_pkg::OP_INSERT:
                        begin
                            done_next = 1'b1;
                            if (occ_reg >= CW'(DEPTH))
                            begin
                                result_next.status      = ldl_pkg::ST_FULL;
                                result_next.valid_count = 7'(live_reg);
                            end
                            else
                            begin
                                // Append a live entry at the newest slot
                                wr_en                   = 1'b1;
                                occ_next                = occ_reg + CW'(1);
                                live_next               = live_reg + CW'(1);
                                result_next.status      = ldl_pkg::ST_DONE;
                                result_next.valid_count = 7'(live_reg + CW'(1));
                            end
                        end
                        ldl_pkg::OP_DEL_NEWEST, ldl_pkg::OP_DEL_OLDEST,
                        ldl_pkg::OP_DEL_VALUE, ldl_pkg::OP_RESTORE:
                        begin
                            if (occ_reg == '0)
                            begin
                                done_next               = 1'b1;
                                result_next.status      = ldl_pkg::ST_NONE;
                                result_next.valid_count = 7'(live_reg);
                            end
                            else
                            begin
                                // Start at the oldest or the newest occupied slot
                                state_next = S_SCAN;
                                left_next  = occ_reg;
                                if (in_item.kind == ldl_pkg::OP_DEL_OLDEST)
                                begin
                                    addr_next = '0;
                                end
                                else
                                begin
                                    addr_next = occ_m1[AW-1:0];
                                end
                            end
                        end
                        ldl_pkg::OP_COUNT:
                        begin
                            done_next               = 1'b1;
                            result_next.status      = ldl_pkg::ST_DONE;
                            result_next.valid_count = 7'(live_reg);
                        end
                        default:
                        begin
                            done_next               = 1'b1;
                            result_next.status      = ldl_pkg::ST_NONE;
                            result_next.valid_count = 7'(live_reg);
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // Issue one read per cycle while slots remain
                if (left_reg != '0)
                begin
                    rd_en      = 1'b1;
                    pend_next  = 1'b1;
                    paddr_next = addr_reg;
                    left_next  = left_reg - CW'(1);
                    addr_next  = go_down ? (addr_reg - AW'(1)) : (addr_reg + AW'(1));
                end

                // Check the entry read in the previous cycle
                if (hit)
                begin
                    // Flip the mark of the found slot; drop any read in flight
                    wr_en              = 1'b1;
                    wr_addr            = paddr_reg;
                    wr_data            = '{live: !rd_data.live, value: rd_data.value};
                    state_next         = S_IDLE;
                    pend_next          = 1'b0;
                    done_next          = 1'b1;
                    result_next.status = ldl_pkg::ST_DONE;
                    if (rd_data.live)
                    begin
                        if (live_reg != '0)
                        begin
                            live_next = live_reg - CW'(1);
                        end
                        result_next.valid_count = 7'(live_next);
                    end
                    else
                    begin
                        live_next               = live_reg + CW'(1);
                        result_next.valid_count = 7'(live_reg + CW'(1));
                    end
                end
                else if (pend_reg && (left_reg == '0))
                begin
                    // Last slot checked without a match
                    state_next              = S_IDLE;
                    done_next               = 1'b1;
                    result_next.status      = ldl_pkg::ST_NONE;
                    result_next.valid_count = 7'(live_reg);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            occ_reg   <= '0;
            live_reg  <= '0;
            left_reg  <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            live_reg  <= live_next;
            left_reg  <= left_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    // Hold item payload and scan addresses; no reset needed
    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        key_reg    <= key_next;
        addr_reg   <= addr_next;
        paddr_reg  <= paddr_next;
        result_reg <= result_next;
    end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the lazy deletion list table
// Drives a short table of directed operations and then long runs of random
// operations through the start/busy port, mostly with random gaps before items.
// Every result is checked against a local model of the table or a pinned answer.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int DEPTH        = 64;
    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 12;
    localparam int MAX_GAP      = 12;
    localparam int STALL_LIMIT  = 4000;
    localparam int MAX_SHOWN    = 10;
    localparam int DRAIN_CYCLES = DEPTH + 8;
    localparam int N_DIRECTED   = 22;

    // Kind codes the block ignores
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    localparam logic [31:0] INT_MIN = 32'h8000_0000;
    localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] ALL_ONE = 32'hFFFF_FFFF;

    // One directed row: the item, and a typed answer when pinned is set
    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] value;
        logic        pinned;
        logic [1:0]  status;
        logic [6:0]  valid_count;
    } table_row_t;

    // Walk from an empty table through the extremes, duplicates, misses
    // and the ignored codes. Rows left unpinned go through the model.
    localparam table_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        {ldl_pkg::OP_COUNT,      32'h0,         1'b1, ldl_pkg::ST_DONE, 7'd0},
        {ldl_pkg::OP_DEL_NEWEST, 32'h0,         1'b1, ldl_pkg::ST_NONE, 7'd0},
        {ldl_pkg::OP_DEL_OLDEST, 32'h0,         1'b1, ldl_pkg::ST_NONE, 7'd0},
        {ldl_pkg::OP_DEL_VALUE,  32'h0,         1'b1, ldl_pkg::ST_NONE, 7'd0},
        {ldl_pkg::OP_RESTORE,    32'h0,         1'b1, ldl_pkg::ST_NONE, 7'd0},
        {ldl_pkg::OP_INSERT,     INT_MIN,       1'b1, ldl_pkg::ST_DONE, 7'd1},
        {ldl_pkg::OP_INSERT,     INT_MAX,       1'b1, ldl_pkg::ST_DONE, 7'd2},
        {ldl_pkg::OP_INSERT,     32'h0,         1'b1, ldl_pkg::ST_DONE, 7'd3},
        {ldl_pkg::OP_INSERT,     ALL_ONE,       1'b1, ldl_pkg::ST_DONE, 7'd4},
        {ldl_pkg::OP_INSERT,     INT_MAX,       1'b1, ldl_pkg::ST_DONE, 7'd5},
        {ldl_pkg::OP_DEL_VALUE,  INT_MAX,       1'b0, ldl_pkg::ST_NONE, 7'd0},
        {ldl_pkg::OP_RESTORE,    INT_MAX,       1'b0, ldl_pkg::ST_NONE, 7'd0},
        {ldl_pkg::OP_DEL_VALUE,  32'h1234_5678, 1'b1, ldl_pkg::ST_NONE, 7'd5},
        {ldl_pkg::OP_RESTORE,    32'h0,         1'b1, ldl_pkg::ST_NONE, 7'd5},
        {OP_SPARE_6,             32'h0,         1'b1, ldl_pkg::ST_NONE, 7'd5},
        {OP_SPARE_7,             ALL_ONE,       1'b1, ldl_pkg::ST_NONE, 7'd5},
        {ldl_pkg::OP_DEL_NEWEST, 32'h0,         1'b0, ldl_pkg::ST_NONE, 7'd0},
        {ldl_pkg::OP_DEL_OLDEST, 32'h0,         1'b0, ldl_pkg::ST_NONE, 7'd0},
        {ldl_pkg::OP_RESTORE,    INT_MIN,       1'b0, ldl_pkg::ST_NONE, 7'd0},
        {ldl_pkg::OP_DEL_VALUE,  INT_MAX,       1'b0, ldl_pkg::ST_NONE, 7'd0},
        {ldl_pkg::OP_DEL_VALUE,  INT_MAX,       1'b0, ldl_pkg::ST_NONE, 7'd0},
        {ldl_pkg::OP_COUNT,      32'h0,         1'b0, ldl_pkg::ST_NONE, 7'd0}
    };

    logic               clk = 1'b0;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               done;
    ldl_pkg::in_item_t  in_item;
    ldl_pkg::out_item_t result;

    // Local copy of the table: stored values, valid marks and counts
    logic [31:0] model_value [DEPTH];
    bit          model_live [DEPTH];
    int          model_fill;
    int          model_live_count;

    // Answers still owed by the block, oldest first
    ldl_pkg::out_item_t pending_results [$];

    int mismatches;
    int results_checked;
    int stall_cycles;
    int full_refusals;
    int kind_seen [8];

    lazy_delete_list_table #(
        .DEPTH (DEPTH)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .in_item (in_item),
        .done    (done),
        .result  (result)
    );

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------
    // Table model: apply one item to the local copy and return the answer.
    // Scans only cover occupied slots, so no unwritten value is compared.
    // ------------------------------------------------------------------
    function automatic ldl_pkg::out_item_t apply_table_op(input ldl_pkg::in_item_t it);
        ldl_pkg::out_item_t answer;
        int                 slot;
        logic [31:0]        key;
        key           = it.value;
        slot          = -1;
        answer.status = ldl_pkg::ST_NONE;
        case (it.kind)
            ldl_pkg::OP_INSERT:
            begin
                if (model_fill >= DEPTH)
                    answer.status = ldl_pkg::ST_FULL;
                else
                begin
                    model_value[model_fill] = key;
                    model_live[model_fill]  = 1'b1;
                    model_fill++;
                    model_live_count++;
                    answer.status = ldl_pkg::ST_DONE;
                end
            end
            ldl_pkg::OP_DEL_NEWEST:
                for (int i = model_fill - 1; i >= 0 && slot < 0; i--)
                    if (model_live[i])
                        slot = i;
            ldl_pkg::OP_DEL_OLDEST:
                for (int i = 0; i < model_fill && slot < 0; i++)
                    if (model_live[i])
                        slot = i;
            ldl_pkg::OP_DEL_VALUE:
                for (int i = model_fill - 1; i >= 0 && slot < 0; i--)
                    if (model_live[i] && model_value[i] == key)
                        slot = i;
            ldl_pkg::OP_RESTORE:
            begin
                for (int i = model_fill - 1; i >= 0 && slot < 0; i--)
                    if (!model_live[i] && model_value[i] == key)
                        slot = i;
                if (slot >= 0)
                begin
                    model_live[slot] = 1'b1;
                    model_live_count++;
                    answer.status = ldl_pkg::ST_DONE;
                end
                slot = -1;
            end
            ldl_pkg::OP_COUNT:
                answer.status = ldl_pkg::ST_DONE;
            default:
                ;
        endcase
        // Lazy delete: drop the valid mark, keep the slot and its value
        if (slot >= 0)
        begin
            model_live[slot] = 1'b0;
            if (model_live_count > 0)
                model_live_count--;
            answer.status = ldl_pkg::ST_DONE;
        end
        answer.valid_count = model_live_count[6:0];
        return answer;
    endfunction

    // Draw a key: extremes, a small pool that breeds duplicates, or any
    // pattern. Delete and restore mostly aim at values already stored.
    function automatic logic [31:0] random_key(input bit from_table);
        logic [31:0] key;
        case ($urandom_range(0, 9))
            0:       key = INT_MIN;
            1:       key = INT_MAX;
            2:       key = ALL_ONE;
            3, 4, 5: key = 32'h0000_00F0 + 32'($urandom_range(0, 7));
            default: key = $urandom;
        endcase
        if (from_table && model_fill > 0 && $urandom_range(0, 9) < 7)
            key = model_value[$urandom_range(0, model_fill - 1)];
        return key;
    endfunction

    function automatic ldl_pkg::in_item_t random_item();
        ldl_pkg::in_item_t it;
        int                pick;
        pick = $urandom_range(0, 99);
        if (pick < 20)
            it.kind = ldl_pkg::OP_INSERT;
        else if (pick < 30)
            it.kind = ldl_pkg::OP_DEL_NEWEST;
        else if (pick < 40)
            it.kind = ldl_pkg::OP_DEL_OLDEST;
        else if (pick < 60)
            it.kind = ldl_pkg::OP_DEL_VALUE;
        else if (pick < 90)
            it.kind = ldl_pkg::OP_RESTORE;
        else if (pick < 95)
            it.kind = ldl_pkg::OP_COUNT;
        else if (pick < 98)
            it.kind = OP_SPARE_6;
        else
            it.kind = OP_SPARE_7;
        it.value = random_key(it.kind == ldl_pkg::OP_DEL_VALUE ||
                              it.kind == ldl_pkg::OP_RESTORE);
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Send one item. Entered and left at a falling edge. Hold start low
    // for the gap, then hold the item until an edge with busy low takes
    // it; the answer owed is queued at that same edge.
    // ------------------------------------------------------------------
    task automatic issue_item(input ldl_pkg::in_item_t it, input int gap,
                              input bit pinned,
                              input ldl_pkg::out_item_t typed_answer);
        ldl_pkg::out_item_t predicted;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start   <= 1'b1;
        in_item <= it;
        do
            @(posedge clk);
        while (busy);
        predicted = apply_table_op(it);
        if (predicted.status == ldl_pkg::ST_FULL)
            full_refusals++;
        kind_seen[it.kind]++;
        pending_results.push_back(pinned ? typed_answer : predicted);
        @(negedge clk);
    endtask

    // Random items; ignored kind codes do not count toward the total
    task automatic run_random(input int items, input bit with_gaps);
        ldl_pkg::in_item_t it;
        int                counted;
        counted = 0;
        while (counted < items)
        begin
            it = random_item();
            issue_item(it, with_gaps ? $urandom_range(0, MAX_GAP) : 0, 1'b0, '0);
            if (it.kind <= ldl_pkg::OP_COUNT)
                counted++;
        end
    endtask

    // Drop start and hold off until every owed answer has come back
    task automatic drain_results();
        start <= 1'b0;
        @(negedge clk);
        while (pending_results.size() > 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Result checker: each strobe is matched against the oldest answer
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        ldl_pkg::out_item_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("[%0t] result with nothing owed: status=%0d count=%0d",
                             $time, result.status, result.valid_count);
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (result.status !== want.status ||
                    result.valid_count !== want.valid_count)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display({"[%0t] mismatch: expected status=%0d count=%0d,",
                                  " got status=%0d count=%0d"},
                                 $time, want.status, want.valid_count,
                                 result.status, result.valid_count);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: count cycles in which no item is taken and no result shows
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("[%0t] watchdog: no progress for %0d cycles, %0d answers owed",
                     $time, STALL_LIMIT, pending_results.size());
            $display("Simulation FAILED");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        table_row_t         row;
        ldl_pkg::in_item_t  it;
        ldl_pkg::out_item_t typed_answer;

        // Hold every input at a known value through reset
        rst_n            = 1'b0;
        start            = 1'b0;
        in_item          = '0;
        model_fill       = 0;
        model_live_count = 0;
        mismatches       = 0;
        results_checked  = 0;
        full_refusals    = 0;
        foreach (kind_seen[k])
            kind_seen[k] = 0;
        foreach (model_live[s])
        begin
            model_live[s]  = 1'b0;
            model_value[s] = '0;
        end

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed walk; pinned rows carry their own answer
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            row                      = DIRECTED_ROWS[i];
            it.kind                  = row.kind;
            it.value                 = row.value;
            typed_answer.status      = row.status;
            typed_answer.valid_count = row.valid_count;
            issue_item(it, $urandom_range(0, MAX_GAP), row.pinned, typed_answer);
        end
        drain_results();

        // Random runs: fill the table, then keep deleting and restoring
        // in a permanently full table. One run has no gaps at all.
        run_random(400, 1'b1);
        drain_results();
        run_random(200, 1'b0);
        drain_results();
        run_random(400, 1'b1);

        // Wait out the last answers, then a scan's worth of cycles more
        start <= 1'b0;
        while (pending_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            mismatches += pending_results.size();

        $display({"Run covered %0d inserts (%0d refused on a full table),",
                  " %0d/%0d/%0d deletes by newest/oldest/value,"},
                 kind_seen[ldl_pkg::OP_INSERT], full_refusals,
                 kind_seen[ldl_pkg::OP_DEL_NEWEST],
                 kind_seen[ldl_pkg::OP_DEL_OLDEST],
                 kind_seen[ldl_pkg::OP_DEL_VALUE]);
        $display({"%0d restores, %0d counts, %0d unused codes;",
                  " %0d results checked, %0d mismatches"},
                 kind_seen[ldl_pkg::OP_RESTORE], kind_seen[ldl_pkg::OP_COUNT],
                 kind_seen[OP_SPARE_6] + kind_seen[OP_SPARE_7],
                 results_checked, mismatches);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: lazy_delete_list_table.f
rtl/ldl_pkg.sv
rtl/ldl_mem.sv
rtl/lazy_delete_list_table.sv
tb/tb_top.sv
